>>> rtl/swish_activation_core_assert.svh
// Assertion macros shared by the swish checker.
`ifndef SWISH_ACTIVATION_CORE_ASSERT_SVH
`define SWISH_ACTIVATION_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SWISH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swish checker: implication failed");

// Implication with the consequent delayed by the macro argument n.
`define SWISH_ASSERT_DLY(label, ante, n, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error("swish checker: delayed implication failed");

`endif

>>> rtl/swish_pkg.sv
`timescale 1ns / 1ps
package swish_pkg;

  localparam int DATA_WIDTH_DEF  = 16;
  localparam int FRAC_BITS_DEF   = 12;
  localparam int SIG_DEPTH_DEF   = 256;
  localparam int SIG_FRAC        = 16;   // sigmoid output, Q0.16
  localparam int TBL_FRAC        = 20;   // table entries, Q0.20
  localparam int EXP_FRAC        = 30;   // table build precision
  localparam int PIPE_LATENCY    = 8;

  // Elaboration-time helpers for the sigmoid table. Shift-subtract divide.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^-r for r in [0,1], Q30, Taylor series
  function automatic logic [63:0] exp_neg_unit(input logic [63:0] r);
    longint      sum;
    logic [63:0] term;
    sum  = longint'(64'd1 << EXP_FRAC);
    term = 64'd1 << EXP_FRAC;
    for (int k = 1; k <= 24; k++) begin
      term = udiv64((term * r) >> EXP_FRAC, 64'(k));
      if ((k & 1) != 0) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  function automatic logic [63:0] exp_neg(input logic [63:0] t);
    logic [63:0] n;
    logic [63:0] v;
    logic [63:0] e1;
    n = t >> EXP_FRAC;
    if (n > 64'd40) return 64'd0;
    v  = exp_neg_unit(t & ((64'd1 << EXP_FRAC) - 64'd1));
    e1 = exp_neg_unit(64'd1 << EXP_FRAC);
    for (int i = 0; i < 40; i++) begin
      if (64'(i) < n) v = (v * e1 + (64'd1 << (EXP_FRAC - 1))) >> EXP_FRAC;
    end
    return v;
  endfunction

  // sigmoid(t), t in Q30, result Q0.20
  function automatic logic [63:0] sig_exact(input logic [63:0] t);
    logic [63:0] d;
    d = (64'd1 << EXP_FRAC) + exp_neg(t);
    return udiv64((64'd1 << (EXP_FRAC + TBL_FRAC)) + (d >> 1), d);
  endfunction

  function automatic logic [63:0] sig_raw(input int k, input int n);
    return sig_exact(udiv64(64'(k) << (EXP_FRAC + 4), 64'(n)));
  endfunction

  // chord sag of segment k
  function automatic longint sig_sag(input int k, input int n);
    logic [63:0] mid;
    if (k >= n) return 0;
    mid = sig_exact(udiv64(64'(2 * k + 1) << (EXP_FRAC + 3), 64'(n)));
    return longint'(mid) - longint'((sig_raw(k, n) + sig_raw(k + 1, n)) >> 1);
  endfunction

  // table entry k, shifted by half the mean sag of its two neighbors
  function automatic logic [TBL_FRAC:0] sig_entry(input int k, input int n);
    longint lft;
    longint rgt;
    longint g;
    lft = (k == 0) ? -sig_sag(0, n) : sig_sag(k - 1, n);
    rgt = sig_sag(k, n);
    g   = longint'(sig_raw(k, n)) + (lft + rgt) / 4;
    if (g < 0) g = 0;
    if (g > (longint'(1) << TBL_FRAC)) g = longint'(1) << TBL_FRAC;
    return g[TBL_FRAC:0];
  endfunction

endpackage

>>> rtl/swish_activation_core.sv
`timescale 1ns / 1ps
// Swish y = x * sigmoid(alpha * x), signed fixed point.
// Each accepted request passes through the stages below to done_o; one request per cycle.
// Stages: alpha*x multiply, round/clamp, table index multiply, table read,
// interpolation multiplies, rounding/mirror, x*sigmoid multiply, round/clamp.
// busy is never raised; the receiver cannot stall. Reset clears the valid
// bits and sets alpha to 1.0.
module swish_activation_core import swish_pkg::*; #(
  parameter int DATA_WIDTH          = DATA_WIDTH_DEF,
  parameter int FRAC_BITS           = FRAC_BITS_DEF,
  parameter int SIGMOID_TABLE_DEPTH = SIG_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [DATA_WIDTH-1:0]  x_sample_i,
  output logic                          done_o,
  output logic signed [DATA_WIDTH-1:0]  y_sample_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic signed [DATA_WIDTH-1:0]  cfg_alpha_i
);

  logic signed [DATA_WIDTH-1:0] alpha_d, alpha_q;
  logic                         accept;
  logic                         a_valid, s_valid;
  logic signed [DATA_WIDTH-1:0] a_x, s_x;
  logic [FRAC_BITS+4:0]         a_t;
  logic                         a_neg;
  logic [SIG_FRAC:0]            s_sig;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign alpha_d     = (cfg_valid_i && cfg_ready_o) ? cfg_alpha_i : alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= DATA_WIDTH'(1) << FRAC_BITS;
    end else begin
      alpha_q <= alpha_d;
    end
  end

  swish_arg #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_arg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .x_i     (x_sample_i),
    .alpha_i (alpha_q),
    .valid_o (a_valid),
    .x_o     (a_x),
    .t_o     (a_t),
    .neg_o   (a_neg)
  );

  swish_sigmoid #(
    .DATA_WIDTH          (DATA_WIDTH),
    .FRAC_BITS           (FRAC_BITS),
    .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
  ) u_sig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_valid),
    .x_i     (a_x),
    .t_i     (a_t),
    .neg_i   (a_neg),
    .valid_o (s_valid),
    .x_o     (s_x),
    .sig_o   (s_sig)
  );

  swish_scale #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .x_i     (s_x),
    .sig_i   (s_sig),
    .valid_o (done_o),
    .y_o     (y_sample_o)
  );

endmodule

>>> rtl/swish_arg.sv
`timescale 1ns / 1ps
module swish_arg import swish_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [DATA_WIDTH-1:0]   x_i,
  input  logic signed [DATA_WIDTH-1:0]   alpha_i,
  output logic                           valid_o,
  output logic signed [DATA_WIDTH-1:0]   x_o,
  output logic [FRAC_BITS+4:0]           t_o,
  output logic                           neg_o
);

  localparam int AS = FRAC_BITS + 4;
  localparam int TW = AS + 1;
  localparam int PW = 2 * DATA_WIDTH;
  localparam int AW = (PW + 1 > AS + 2) ? PW + 1 : AS + 2;
  localparam logic signed [AW-1:0] HalfA = AW'(1) << (FRAC_BITS - 1);
  localparam logic signed [AW-1:0] LimA  = AW'(1) << AS;

  logic signed [PW-1:0]         prod_d, prod_q;
  logic signed [DATA_WIDTH-1:0] x1_q, x2_q;
  logic                         v1_q, v2_q;
  logic signed [AW-1:0]         prod_ext, ax, mag;
  logic [TW-1:0]                t_d, t_q;
  logic                         neg_d, neg_q;

  assign prod_d = alpha_i * x_i;

  // round alpha*x back to Q.F and clamp to +-16
  always_comb begin
    prod_ext = $signed({{(AW - PW){prod_q[PW-1]}}, prod_q});
    ax       = (prod_ext + HalfA) >>> FRAC_BITS;
    if (ax > LimA) begin
      mag   = LimA;
      neg_d = 1'b0;
    end else if (ax < -LimA) begin
      mag   = LimA;
      neg_d = 1'b1;
    end else if (ax < 0) begin
      mag   = -ax;
      neg_d = 1'b1;
    end else begin
      mag   = ax;
      neg_d = 1'b0;
    end
    t_d = mag[TW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    x1_q   <= x_i;
    t_q    <= t_d;
    neg_q  <= neg_d;
    x2_q   <= x1_q;
  end

  assign valid_o = v2_q;
  assign x_o     = x2_q;
  assign t_o     = t_q;
  assign neg_o   = neg_q;

endmodule

>>> rtl/swish_sigmoid.sv
`timescale 1ns / 1ps
module swish_sigmoid import swish_pkg::*; #(
  parameter int DATA_WIDTH          = DATA_WIDTH_DEF,
  parameter int FRAC_BITS           = FRAC_BITS_DEF,
  parameter int SIGMOID_TABLE_DEPTH = SIG_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [DATA_WIDTH-1:0]  x_i,
  input  logic [FRAC_BITS+4:0]          t_i,
  input  logic                          neg_i,
  output logic                          valid_o,
  output logic signed [DATA_WIDTH-1:0]  x_o,
  output logic [SIG_FRAC:0]             sig_o
);

  localparam int N    = SIGMOID_TABLE_DEPTH;
  localparam int AS   = FRAC_BITS + 4;
  localparam int TW   = AS + 1;
  localparam int IW   = $clog2(N + 1);
  localparam int PW   = TW + IW;
  localparam int BANK = (N + 1) / 2 + 1;
  localparam int BW   = $clog2(BANK);
  localparam int RW   = TBL_FRAC + 1;
  localparam int MW   = RW + TW;
  localparam int SH   = AS + TBL_FRAC - SIG_FRAC;
  localparam logic [MW:0]       HalfS = (MW + 1)'(1) << (SH - 1);
  localparam logic [TW-1:0]     Span  = TW'(1) << AS;
  localparam logic [SIG_FRAC:0] One   = (SIG_FRAC + 1)'(1) << SIG_FRAC;

  typedef logic [RW-1:0] bank_t [BANK];

  // even / odd banks so entries idx and idx+1 come from different tables
  function automatic bank_t build_bank(input int odd);
    bank_t b;
    int    k;
    for (int j = 0; j < BANK; j++) begin
      k = 2 * j + odd;
      if (k > N) k = N;
      b[j] = sig_entry(k, N);
    end
    return b;
  endfunction

  localparam bank_t EvRom = build_bank(0);
  localparam bank_t OdRom = build_bank(1);

  logic                         v3_q, v4_q, v5_q, v6_q;
  logic signed [DATA_WIDTH-1:0] x3_q, x4_q, x5_q, x6_q;
  logic                         n3_q, n4_q, n5_q;
  logic [PW-1:0]                pos_d, pos_q;
  logic [IW-1:0]                idx;
  logic [IW:0]                  idx_p1;
  logic [BW-1:0]                ev_addr, od_addr;
  logic [RW-1:0]                ev_q, od_q, lo, hi;
  logic                         odd_q;
  logic [AS-1:0]                fr_q;
  logic [MW-1:0]                m0_q, m1_q;
  logic [MW:0]                  acc;
  logic [SIG_FRAC:0]            sp, sig_d, sig_q;

  assign pos_d   = PW'(t_i) * PW'(N);
  assign idx     = pos_q[AS +: IW];
  assign idx_p1  = {1'b0, idx} + 1'b1;
  assign ev_addr = idx_p1[BW:1];
  assign od_addr = idx[BW:1];

  always_comb begin
    lo    = odd_q ? od_q : ev_q;
    hi    = odd_q ? ev_q : od_q;
    acc   = {1'b0, m0_q} + {1'b0, m1_q} + HalfS;
    sp    = acc[SH +: SIG_FRAC + 1];
    // negative argument: 1 - sigmoid(|arg|)
    sig_d = n5_q ? One - sp : sp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v3_q <= valid_i;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    x3_q  <= x_i;
    n3_q  <= neg_i;
    ev_q  <= EvRom[ev_addr];
    od_q  <= OdRom[od_addr];
    odd_q <= idx[0];
    fr_q  <= pos_q[AS-1:0];
    x4_q  <= x3_q;
    n4_q  <= n3_q;
    m0_q  <= MW'(lo) * MW'(Span - {1'b0, fr_q});
    m1_q  <= MW'(hi) * MW'(fr_q);
    x5_q  <= x4_q;
    n5_q  <= n4_q;
    x6_q  <= x5_q;
    sig_q <= sig_d;
  end

  assign valid_o = v6_q;
  assign x_o     = x6_q;
  assign sig_o   = sig_q;

endmodule

>>> rtl/swish_scale.sv
`timescale 1ns / 1ps
module swish_scale import swish_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [DATA_WIDTH-1:0]  x_i,
  input  logic [SIG_FRAC:0]             sig_i,
  output logic                          valid_o,
  output logic signed [DATA_WIDTH-1:0]  y_o
);

  localparam int YW = DATA_WIDTH + SIG_FRAC + 2;
  localparam logic signed [YW-1:0] HalfY = YW'(1) << (SIG_FRAC - 1);
  localparam logic signed [YW-1:0] YMax  = (YW'(1) << (DATA_WIDTH - 1)) - YW'(1);
  localparam logic signed [YW-1:0] YMin  = -(YW'(1) << (DATA_WIDTH - 1));

  logic                          v7_q, v8_q;
  logic signed [YW-1:0]          yp_d, yp_q, yr;
  logic signed [DATA_WIDTH-1:0]  y_d, y_q;

  assign yp_d = x_i * $signed({1'b0, sig_i});

  always_comb begin
    yr = (yp_q + HalfY) >>> SIG_FRAC;
    if (yr > YMax)      y_d = YMax[DATA_WIDTH-1:0];
    else if (yr < YMin) y_d = YMin[DATA_WIDTH-1:0];
    else                y_d = yr[DATA_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      v7_q <= valid_i;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    yp_q <= yp_d;
    y_q  <= y_d;
  end

  assign valid_o = v8_q;
  assign y_o     = y_q;

endmodule

>>> rtl/swish_activation_core_chk.sv
`timescale 1ns / 1ps
`include "swish_activation_core_assert.svh"
module swish_activation_core_chk import swish_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic signed [DATA_WIDTH-1:0]  x_sample_i,
  input logic                          done_o,
  input logic signed [DATA_WIDTH-1:0]  y_sample_o
);

  localparam int Lat = PIPE_LATENCY;

  logic                         req;
  logic                         ok_mag;
  logic signed [DATA_WIDTH-1:0] x_hist_q [Lat];
  logic signed [DATA_WIDTH-1:0] x_old;

  assign req = start && !busy;

  // x delayed through the Lat history registers, lined up with done_o
  always_ff @(posedge clk_i) begin
    x_hist_q[0] <= x_sample_i;
    for (int i = 1; i < Lat; i++) x_hist_q[i] <= x_hist_q[i-1];
  end

  assign x_old = x_hist_q[Lat-1];

  // |y| <= |x| and y keeps the sign of x (or is zero)
  assign ok_mag = (x_old >= 0)
                  ? (y_sample_o >= 0 && y_sample_o <= x_old)
                  : (y_sample_o <= 0 && y_sample_o >= x_old);

  `SWISH_ASSERT_DLY(a_req_done, req, Lat, done_o)
  `SWISH_ASSERT_DLY(a_no_spurious, !req, Lat, !done_o)
  `SWISH_ASSERT_IMP(a_mag_bound, done_o, ok_mag)

endmodule

bind swish_activation_core swish_activation_core_chk #(
  .DATA_WIDTH (DATA_WIDTH)
) u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .x_sample_i  (x_sample_i),
  .done_o      (done_o),
  .y_sample_o  (y_sample_o)
);

>>> sim/swish_check.sv
`timescale 1ns / 1ps
module swish_check import swish_pkg::*; (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_start_i,
  input  logic                              req_busy_i,
  input  logic signed [DATA_WIDTH_DEF-1:0]  req_x_i,
  input  logic                              rsp_done_i,
  input  logic signed [DATA_WIDTH_DEF-1:0]  rsp_y_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic signed [DATA_WIDTH_DEF-1:0]  cfg_alpha_i,
  output int                                pending_o,
  output int                                fail_count_o
);

  typedef longint unsigned u64_t;

  localparam int DW        = DATA_WIDTH_DEF;
  localparam int FRAC      = FRAC_BITS_DEF;
  localparam int DEPTH     = SIG_DEPTH_DEF;
  localparam int ARG_SHIFT = FRAC + 4;           // argument span is [0, 16]
  localparam int GUARD     = TBL_FRAC - SIG_FRAC;
  localparam logic signed [DW-1:0] ALPHA_ONE = DW'(1 <<< FRAC);

  u64_t                  sig_table [0:DEPTH];   // Q0.20 sigmoid over [0, 16]
  logic signed [DW-1:0]  alpha_q;
  logic signed [DW-1:0]  y_expected [$];
  logic signed [DW-1:0]  y_want;

  // e^-r, r in [0, 1], Q30 Taylor series
  function automatic u64_t exp_neg_frac(input u64_t r);
    longint acc;
    u64_t   term;
    acc  = longint'(u64_t'(1) << EXP_FRAC);
    term = u64_t'(1) << EXP_FRAC;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * r) >> EXP_FRAC) / u64_t'(k);
      if (k % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    return (acc < 0) ? u64_t'(0) : u64_t'(acc);
  endfunction

  function automatic u64_t exp_neg_q30(input u64_t t);
    u64_t whole;
    u64_t v;
    u64_t e1;
    whole = t >> EXP_FRAC;
    if (whole > 40) return 0;
    v  = exp_neg_frac(t & ((u64_t'(1) << EXP_FRAC) - 1));
    e1 = exp_neg_frac(u64_t'(1) << EXP_FRAC);
    for (u64_t i = 0; i < whole; i++)
      v = (v * e1 + (u64_t'(1) << (EXP_FRAC - 1))) >> EXP_FRAC;
    return v;
  endfunction

  function automatic u64_t sigmoid_q20(input u64_t t);
    u64_t d;
    d = (u64_t'(1) << EXP_FRAC) + exp_neg_q30(t);
    return ((u64_t'(1) << (EXP_FRAC + TBL_FRAC)) + d / 2) / d;
  endfunction

  // table lookup with linear interpolation, t in [0, 16.0], Q0.16 result
  function automatic longint sigmoid_q16(input longint t);
    u64_t span;
    u64_t prod;
    u64_t idx;
    u64_t fr;
    u64_t acc;
    span = u64_t'(1) << ARG_SHIFT;
    prod = u64_t'(t) * u64_t'(DEPTH);
    idx  = prod >> ARG_SHIFT;
    fr   = prod & (span - 1);
    if (idx >= DEPTH)
      return longint'((sig_table[DEPTH] + (u64_t'(1) << (GUARD - 1))) >> GUARD);
    acc = sig_table[idx] * (span - fr) + sig_table[idx + 1] * fr;
    return longint'((acc + (u64_t'(1) << (ARG_SHIFT + GUARD - 1))) >> (ARG_SHIFT + GUARD));
  endfunction

  function automatic logic signed [DW-1:0] swish_y(input logic signed [DW-1:0] x,
                                                   input logic signed [DW-1:0] a);
    longint lim;
    longint ymax;
    longint ax;
    longint sig;
    longint y;
    lim  = longint'(16) <<< FRAC;
    ymax = (longint'(1) <<< (DW - 1)) - 1;
    ax   = (longint'(a) * longint'(x) + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    if (ax > lim)  ax = lim;
    if (ax < -lim) ax = -lim;
    // negative side mirrors the positive table
    if (ax >= 0) sig = sigmoid_q16(ax);
    else         sig = (longint'(1) <<< SIG_FRAC) - sigmoid_q16(-ax);
    y = (longint'(x) * sig + (longint'(1) <<< (SIG_FRAC - 1))) >>> SIG_FRAC;
    if (y > ymax)     y = ymax;
    if (y < -ymax - 1) y = -ymax - 1;
    return y[DW-1:0];
  endfunction

  // entries are pulled off the exact curve by half the mean chord sag
  initial begin : build_table
    longint sag [0:DEPTH];
    longint lft;
    longint rgt;
    longint g;
    for (int k = 0; k <= DEPTH; k++)
      sig_table[k] = sigmoid_q20((u64_t'(k) << (EXP_FRAC + 4)) / u64_t'(DEPTH));
    for (int k = 0; k < DEPTH; k++)
      sag[k] = longint'(sigmoid_q20((u64_t'(2 * k + 1) << (EXP_FRAC + 3)) / u64_t'(DEPTH)))
               - longint'((sig_table[k] + sig_table[k + 1]) / 2);
    sag[DEPTH] = 0;
    for (int k = 0; k <= DEPTH; k++) begin
      lft = (k == 0) ? -sag[0] : sag[k - 1];
      rgt = sag[k];
      g   = longint'(sig_table[k]) + (lft + rgt) / 4;
      if (g < 0) g = 0;
      if (g > (longint'(1) <<< TBL_FRAC)) g = longint'(1) <<< TBL_FRAC;
      sig_table[k] = u64_t'(g);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q = ALPHA_ONE;
      y_expected.delete();
      pending_o = 0;
    end else begin
      if ($isunknown(rsp_done_i)) begin
        $display("%0t: done_o unknown: expected 0 or 1, actual %b", $time, rsp_done_i);
        fail_count_o = fail_count_o + 1;
      end else if (rsp_done_i) begin
        if (y_expected.size() == 0) begin
          $display("%0t: y_sample with no request pending: expected none, actual %0d",
                   $time, rsp_y_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          y_want = y_expected.pop_front();
          if (rsp_y_i !== y_want) begin
            $display("%0t: y_sample mismatch: expected %0d, actual %0d",
                     $time, y_want, rsp_y_i);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (req_start_i && req_busy_i === 1'b0)
        y_expected.push_back(swish_y(req_x_i, alpha_q));
      if (cfg_valid_i && cfg_ready_i === 1'b1)
        alpha_q = cfg_alpha_i;
      pending_o = y_expected.size();
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import swish_pkg::*;

  localparam int DW             = DATA_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SEGMENTS       = 12;   // 4 slope settings per idle phase
  localparam int SEG_ITEMS      = 44;
  localparam int IDLE_FIRST     = 35;
  localparam int IDLE_SECOND    = 87;
  localparam logic signed [DW-1:0] X_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] X_MIN = {1'b1, {(DW-1){1'b0}}};

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  logic signed [DW-1:0]  x_sample_i  = '0;
  logic                  done_o;
  logic signed [DW-1:0]  y_sample_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic signed [DW-1:0]  cfg_alpha_i = '0;

  int                    pending;
  int                    fail_count;
  int                    stall_cycles = 0;
  logic signed [DW-1:0]  alpha_plan [SEGMENTS];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  swish_activation_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .x_sample_i  (x_sample_i),
    .done_o      (done_o),
    .y_sample_o  (y_sample_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_alpha_i (cfg_alpha_i)
  );

  swish_check u_swish_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_start_i  (start),
    .req_busy_i   (busy),
    .req_x_i      (x_sample_i),
    .rsp_done_i   (done_o),
    .rsp_y_i      (y_sample_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_alpha_i  (cfg_alpha_i),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // watchdog: cycles with no request, result or register write
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((start && busy === 1'b0) || done_o === 1'b1
                 || (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("** swish_activation_core: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_sample(input logic signed [DW-1:0] x, input int idle_pct);
    while (int'($urandom_range(99)) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start      <= 1'b1;
    x_sample_i <= x;
    do @(posedge clk_i); while (busy !== 1'b0);
    @(negedge clk_i);
  endtask

  task automatic write_alpha(input logic signed [DW-1:0] a);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_alpha_i <= a;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [DW-1:0] pick_sample();
    logic [DW-1:0] r;
    int            sel;
    sel = $urandom_range(99);
    if (sel < 60) begin
      r = DW'($urandom);
    end else if (sel < 85) begin
      r = DW'(int'($urandom_range(8192)) - 4096);   // near zero, fine steps
    end else begin
      case ($urandom_range(4))
        0:       r = X_MAX;
        1:       r = X_MIN;
        2:       r = '0;
        3:       r = '1;
        default: r = 1;
      endcase
    end
    return r;
  endfunction

  initial begin
    alpha_plan[0]  = 32767;
    alpha_plan[1]  = DW'($urandom);
    alpha_plan[2]  = DW'(int'($urandom_range(16384)) - 8192);
    alpha_plan[3]  = -4096;
    alpha_plan[4]  = -32768;
    alpha_plan[5]  = DW'($urandom);
    alpha_plan[6]  = 8192;
    alpha_plan[7]  = -1;
    alpha_plan[8]  = 4096;
    alpha_plan[9]  = DW'($urandom);
    alpha_plan[10] = DW'(int'($urandom_range(16384)) - 8192);
    alpha_plan[11] = 1;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // slope 1.0 from reset: extremes and a few plain points
    push_sample(0, IDLE_FIRST);
    push_sample(1, IDLE_FIRST);
    push_sample(-1, IDLE_FIRST);
    push_sample(X_MAX, IDLE_FIRST);
    push_sample(X_MIN, IDLE_FIRST);
    push_sample(4096, IDLE_FIRST);
    push_sample(-4096, IDLE_FIRST);
    push_sample(2048, IDLE_FIRST);
    // zero slope: sigmoid is one half, so y lands on rounding ties
    write_alpha(0);
    push_sample(1, IDLE_FIRST);
    push_sample(-1, IDLE_FIRST);
    push_sample(3, IDLE_FIRST);
    push_sample(-3, IDLE_FIRST);
    // tiny slope: alpha*x ties at half an LSB
    write_alpha(1);
    push_sample(2048, IDLE_FIRST);
    push_sample(-2048, IDLE_FIRST);
    push_sample(6144, IDLE_FIRST);
    // slope 4.0: argument exactly +16.0 / -16.0, last table entry
    write_alpha(16384);
    push_sample(16384, IDLE_FIRST);
    push_sample(-16384, IDLE_FIRST);
    push_sample(16383, IDLE_FIRST);
    // extreme slopes: product clamps
    write_alpha(X_MAX);
    push_sample(X_MAX, IDLE_FIRST);
    push_sample(X_MIN, IDLE_FIRST);
    push_sample(100, IDLE_FIRST);
    write_alpha(X_MIN);
    push_sample(X_MAX, IDLE_FIRST);
    push_sample(X_MIN, IDLE_FIRST);
    push_sample(-1, IDLE_FIRST);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      write_alpha(alpha_plan[seg]);
      repeat (SEG_ITEMS)
        push_sample(pick_sample(), (seg < 4) ? IDLE_FIRST : (seg < 8) ? IDLE_SECOND : 0);
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (PIPE_LATENCY + 4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("** swish_activation_core: PASSED **");
    end else begin
      $display("** swish_activation_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/swish_pkg.sv
rtl/swish_arg.sv
rtl/swish_sigmoid.sv
rtl/swish_scale.sv
rtl/swish_activation_core.sv
rtl/swish_activation_core_chk.sv
sim/swish_check.sv
sim/testbench.sv
